@@ rtl/core/qte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion to Euler shared definitions
// Widths, constants, the arctangent table and the CORDIC cell payload type.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_TAB_LEN     = 24;

   localparam int QW  = 16;   // input component width, Q1.14
   localparam int PW  = 32;   // product width, Q.28
   localparam int SW  = 34;   // sum of products width, Q.28
   localparam int DW  = 37;   // CORDIC x and y width, Q.28
   localparam int AW  = 35;   // CORDIC angle width, Q.30
   localparam int MW  = 28;   // pitch argument magnitude width when not clamped
   localparam int RW  = 57;   // radicand width
   localparam int RSW = 58;   // square root partial result width
   localparam int CW  = 29;   // square root result width
   localparam int SQ_CELLS = 29;

   localparam logic signed [AW-1:0] PI_Q30 = AW'(64'sd3373259426);
   localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);
   localparam logic signed [15:0] PI_Q13 = 16'sd25736;
   localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

   typedef struct packed {
      logic                 hold;
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [AW-1:0] z;
   } cordic_vec_type;

   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h3243F6A8;
         1: v = 32'h1DAC6705;
         2: v = 32'h0FADBAFC;
         3: v = 32'h07F56EA6;
         4: v = 32'h03FEAB76;
         5: v = 32'h01FFD55B;
         6: v = 32'h00FFFAAA;
         7: v = 32'h007FFF55;
         8: v = 32'h003FFFEA;
         9: v = 32'h001FFFFD;
         10: v = 32'h00100000;
         11: v = 32'h00080000;
         12: v = 32'h00040000;
         13: v = 32'h00020000;
         14: v = 32'h00010000;
         15: v = 32'h00008000;
         16: v = 32'h00004000;
         17: v = 32'h00002000;
         18: v = 32'h00001000;
         19: v = 32'h00000800;
         20: v = 32'h00000400;
         21: v = 32'h00000200;
         22: v = 32'h00000100;
         23: v = 32'h00000080;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/core/qte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion to Euler channels
// Valid/ready channels for quaternion beats and Euler angle beats.
// ----------------------------------------------------------------------------
interface qte_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;
   logic signed [14:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic               pitch_clamped;

   modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   input ready);
   modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 output ready);
endinterface

@@ rtl/core/qte_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one result bit of a restoring integer square root per cycle while enabled.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
   parameter int BIT_POS = 56
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [qte_pkg::RW-1:0]      rad_in,
   input  logic [qte_pkg::RSW-1:0]     res_in,
   output logic [qte_pkg::RW-1:0]      rad_ff,
   output logic [qte_pkg::RSW-1:0]     res_ff
);

   localparam logic [qte_pkg::RSW-1:0] BIT_VAL = qte_pkg::RSW'(1) << BIT_POS;

   logic [qte_pkg::RSW-1:0] trial;
   logic [qte_pkg::RSW-1:0] rad_ext;
   logic [qte_pkg::RW-1:0]  rad_in_d;
   logic [qte_pkg::RSW-1:0] res_in_d;

   assign trial   = res_in + BIT_VAL;
   assign rad_ext = {1'b0, rad_in};

   always_comb begin
      if (rad_ext >= trial) begin
         rad_in_d = qte_pkg::RW'(rad_ext - trial);
         res_in_d = (res_in >> 1) + BIT_VAL;
      end else begin
         rad_in_d = rad_in;
         res_in_d = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff <= rad_in_d;
         res_ff <= res_in_d;
      end
   end

endmodule

@@ rtl/core/qte_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward the x axis, accumulating the arctangent step; a held vector passes unchanged.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     enable,
   input  qte_pkg::cordic_vec_type  vec_in,
   output qte_pkg::cordic_vec_type  vec_ff
);

   localparam logic signed [qte_pkg::AW-1:0] ATAN_STEP =
      qte_pkg::AW'(qte_pkg::atan_entry(STEP));

   qte_pkg::cordic_vec_type  vec_in_d;
   logic signed [qte_pkg::DW-1:0] xs;
   logic signed [qte_pkg::DW-1:0] ys;

   assign xs = vec_in.x >>> STEP;
   assign ys = vec_in.y >>> STEP;

   always_comb begin
      vec_in_d = vec_in;
      if (!vec_in.hold) begin
         if (vec_in.y >= 0) begin
            vec_in_d.x = vec_in.x + ys;
            vec_in_d.y = vec_in.y - xs;
            vec_in_d.z = vec_in.z + ATAN_STEP;
         end else begin
            vec_in_d.x = vec_in.x - ys;
            vec_in_d.y = vec_in.y + xs;
            vec_in_d.z = vec_in.z - ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in_d;
      end
   end

endmodule

@@ rtl/core/quaternion_to_euler.sv @@
`timescale 1ns / 1ps
// A beat passes input, product, sum, square, radicand, sqrt, CORDIC and output registers.
// Throughput: one beat per cycle, set by the fully pipelined square root and CORDIC rows.
// A result not taken holds the whole pipeline, which resumes when it is taken.
// Reset clears only the valid bits of the pipeline and the output register.
// ----------------------------------------------------------------------------
// Quaternion to Euler converter
// Converts a unit quaternion to ZYX roll, pitch and yaw with CORDIC cell rows.
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input logic         clock,
   input logic         reset,
   qte_req_if.sink     req_bus,
   qte_rsp_if.source   rsp_bus
);

   localparam int SQ  = qte_pkg::SQ_CELLS;
   localparam int NSTG = 5 + SQ + 1 + CORDIC_STEPS;
   localparam int SIDE_D = 2 + SQ;

   typedef struct packed {
      logic signed [qte_pkg::SW-1:0] sr;
      logic signed [qte_pkg::SW-1:0] cr;
      logic signed [qte_pkg::SW-1:0] sy;
      logic signed [qte_pkg::SW-1:0] cy;
      logic signed [qte_pkg::SW-1:0] sp;
      logic                          clamp;
   } side_type;

   function automatic qte_pkg::cordic_vec_type prerotate(
      input logic signed [qte_pkg::SW-1:0] y,
      input logic signed [qte_pkg::SW-1:0] x
   );
      qte_pkg::cordic_vec_type v;
      v.hold = 1'b0;
      v.x = qte_pkg::DW'(x);
      v.y = qte_pkg::DW'(y);
      v.z = '0;
      if (y == 0) begin
         v.hold = 1'b1;
         v.z = (x < 0) ? qte_pkg::PI_Q30 : '0;
      end else if (x < 0) begin
         v.z = (y >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
         v.x = -qte_pkg::DW'(x);
         v.y = -qte_pkg::DW'(y);
      end
      return v;
   endfunction

   function automatic logic signed [15:0] to_q13(
      input logic signed [qte_pkg::AW-1:0] z,
      input logic signed [15:0]            lim
   );
      logic signed [qte_pkg::AW:0]   t;
      logic signed [qte_pkg::AW-17:0] r;
      t = (qte_pkg::AW+1)'(z) + (qte_pkg::AW+1)'(65536);
      r = (qte_pkg::AW-16)'(t >>> 17);
      if (r > (qte_pkg::AW-16)'(lim)) begin
         return lim;
      end else if (r < -(qte_pkg::AW-16)'(lim)) begin
         return -lim;
      end
      return 16'(r);
   endfunction

   logic adv;
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic            out_valid_ff;
   logic            out_valid_in;

   logic signed [qte_pkg::QW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [qte_pkg::PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff;
   logic signed [qte_pkg::PW-1:0] zz_ff;
   side_type                      sum_ff;
   side_type                      sum_in;
   side_type                      side_ff [SIDE_D];
   logic [qte_pkg::MW-1:0]        mag;
   logic signed [qte_pkg::SW-1:0] mag_full;
   logic [2*qte_pkg::MW-1:0]      sq_ff;
   logic [qte_pkg::RW-1:0]        rad_ff;

   logic [qte_pkg::RW-1:0]  sq_rad [SQ+1];
   logic [qte_pkg::RSW-1:0] sq_res [SQ+1];

   qte_pkg::cordic_vec_type roll_vec [CORDIC_STEPS+1];
   qte_pkg::cordic_vec_type yaw_vec [CORDIC_STEPS+1];
   qte_pkg::cordic_vec_type pitch_vec [CORDIC_STEPS+1];
   logic                    clamp_c_ff [CORDIC_STEPS+1];
   logic                    sign_c_ff [CORDIC_STEPS+1];

   logic signed [qte_pkg::SW-1:0] pitch_x;

   logic signed [15:0] roll_ff, yaw_ff;
   logic signed [14:0] pitch_ff;
   logic               clamp_ff;

   assign adv = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign valid_in = {valid_ff[NSTG-2:0], req_bus.valid};
   assign out_valid_in = adv ? valid_ff[NSTG-1] : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            valid_ff <= valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      sum_in.sr = (qte_pkg::SW'(wx_ff) + qte_pkg::SW'(yz_ff)) <<< 1;
      sum_in.cr = qte_pkg::ONE_Q28 - ((qte_pkg::SW'(xx_ff) + qte_pkg::SW'(yy_ff)) <<< 1);
      sum_in.sp = (qte_pkg::SW'(wy_ff) - qte_pkg::SW'(zx_ff)) <<< 1;
      sum_in.sy = (qte_pkg::SW'(wz_ff) + qte_pkg::SW'(xy_ff)) <<< 1;
      sum_in.cy = qte_pkg::ONE_Q28 - ((qte_pkg::SW'(yy_ff) + qte_pkg::SW'(zz_ff)) <<< 1);
      sum_in.clamp = (sum_in.sp >= qte_pkg::ONE_Q28) || (sum_in.sp <= -qte_pkg::ONE_Q28);
   end

   assign mag_full = (sum_ff.sp < 0) ? -sum_ff.sp : sum_ff.sp;
   assign mag = mag_full[qte_pkg::MW-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff <= req_bus.quat_x;
         qy_ff <= req_bus.quat_y;
         qz_ff <= req_bus.quat_z;
         qw_ff <= req_bus.quat_w;
         wx_ff <= qw_ff * qx_ff;
         yz_ff <= qy_ff * qz_ff;
         xx_ff <= qx_ff * qx_ff;
         yy_ff <= qy_ff * qy_ff;
         wy_ff <= qw_ff * qy_ff;
         zx_ff <= qz_ff * qx_ff;
         wz_ff <= qw_ff * qz_ff;
         xy_ff <= qx_ff * qy_ff;
         zz_ff <= qz_ff * qz_ff;
         sum_ff <= sum_in;
         sq_ff <= mag * mag;
         rad_ff <= (qte_pkg::RW'(1) << (qte_pkg::RW-1)) - qte_pkg::RW'(sq_ff);
         side_ff[0] <= sum_ff;
         for (int i = 1; i < SIDE_D; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign sq_rad[0] = rad_ff;
   assign sq_res[0] = '0;

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      qte_sqrt_cell #(
         .BIT_POS(qte_pkg::RW - 1 - 2*k)
      ) u_cell (
         .clock  (clock),
         .enable (adv),
         .rad_in (sq_rad[k]),
         .res_in (sq_res[k]),
         .rad_ff (sq_rad[k+1]),
         .res_ff (sq_res[k+1])
      );
   end

   assign pitch_x = qte_pkg::SW'(sq_res[SQ][qte_pkg::CW-1:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_vec[0]  <= prerotate(side_ff[SIDE_D-1].sr, side_ff[SIDE_D-1].cr);
         yaw_vec[0]   <= prerotate(side_ff[SIDE_D-1].sy, side_ff[SIDE_D-1].cy);
         pitch_vec[0] <= prerotate(side_ff[SIDE_D-1].sp, pitch_x);
         clamp_c_ff[0] <= side_ff[SIDE_D-1].clamp;
         sign_c_ff[0]  <= side_ff[SIDE_D-1].sp > 0;
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            clamp_c_ff[i] <= clamp_c_ff[i-1];
            sign_c_ff[i]  <= sign_c_ff[i-1];
         end
      end
   end

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
      qte_cordic_cell #(.STEP(s)) u_roll (
         .clock (clock), .enable (adv), .vec_in (roll_vec[s]), .vec_ff (roll_vec[s+1])
      );
      qte_cordic_cell #(.STEP(s)) u_yaw (
         .clock (clock), .enable (adv), .vec_in (yaw_vec[s]), .vec_ff (yaw_vec[s+1])
      );
      qte_cordic_cell #(.STEP(s)) u_pitch (
         .clock (clock), .enable (adv), .vec_in (pitch_vec[s]), .vec_ff (pitch_vec[s+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff <= to_q13(roll_vec[CORDIC_STEPS].z, qte_pkg::PI_Q13);
         yaw_ff  <= to_q13(yaw_vec[CORDIC_STEPS].z, qte_pkg::PI_Q13);
         clamp_ff <= clamp_c_ff[CORDIC_STEPS];
         if (clamp_c_ff[CORDIC_STEPS]) begin
            pitch_ff <= sign_c_ff[CORDIC_STEPS] ? 15'(qte_pkg::HALF_PI_Q13)
                                              : 15'(-qte_pkg::HALF_PI_Q13);
         end else begin
            pitch_ff <= 15'(to_q13(pitch_vec[CORDIC_STEPS].z, qte_pkg::HALF_PI_Q13));
         end
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.roll_angle    = roll_ff;
   assign rsp_bus.pitch_angle   = pitch_ff;
   assign rsp_bus.yaw_angle     = yaw_ff;
   assign rsp_bus.pitch_clamped = clamp_ff;

   // A clamped pitch always reads as plus or minus a quarter turn.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && clamp_ff |-> pitch_ff == 15'sd12868 || pitch_ff == -15'sd12868)
      else $error("clamped pitch is not a quarter turn");

   // Roll and yaw stay within the half-turn limits.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> roll_ff <= qte_pkg::PI_Q13 && roll_ff >= -qte_pkg::PI_Q13 &&
                       yaw_ff <= qte_pkg::PI_Q13 && yaw_ff >= -qte_pkg::PI_Q13)
      else $error("roll or yaw outside limits");

   // A held pipeline keeps its occupancy.
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved while held");

   // A beat in the last stage reaches the output register when the pipeline advances.
   assert property (@(posedge clock) disable iff (reset)
      adv && valid_ff[NSTG-1] |=> out_valid_ff)
      else $error("result beat lost");

endmodule

@@ test/qte_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The channels themselves come from the block's interface file; this file
// holds the helper types that the bench shares between its processes.
// ----------------------------------------------------------------------------
package qte_tb_pkg;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } euler_type;

endpackage

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion to Euler converter testbench
// Drives quaternion beats in random bursts, computes the expected roll, pitch
// and yaw with a bit-exact CORDIC model and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STEPS = 16;
   localparam int LATENCY = 35 + STEPS;
   localparam longint ONE28 = 64'sd268435456;
   localparam longint PI30 = 64'sd3373259426;
   localparam longint LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycles = 0;
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int clamps_seen = 0;
   int burst_left = 0;
   qte_tb_pkg::euler_type angle_queue[$];

   qte_req_if req_bus ();
   qte_rsp_if rsp_bus ();

   quaternion_to_euler #(.CORDIC_STEPS(STEPS)) DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_val(int i);
      longint tab[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
         64'h001FFFFD, 64'h00100000, 64'h00080000, 64'h00040000, 64'h00020000,
         64'h00010000, 64'h00008000, 64'h00004000, 64'h00002000, 64'h00001000,
         64'h00000800, 64'h00000400, 64'h00000200, 64'h00000100, 64'h00000080};
      return tab[i];
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint a;
      longint xs;
      longint ys;
      a = 0;
      if (y == 0) return (x < 0) ? PI30 : 0;
      if (x < 0) begin
         a = (y >= 0) ? PI30 : -PI30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = asr(x, i);
         ys = asr(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            a = a + atan_val(i);
         end else begin
            x = x - ys;
            y = y + xs;
            a = a - atan_val(i);
         end
      end
      return a;
   endfunction

   function automatic longint round_angle(longint a, longint lim);
      longint r;
      r = asr(a + 65536, 17);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint floor_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function automatic qte_tb_pkg::euler_type predict_angles(
      logic signed [15:0] qx, logic signed [15:0] qy,
      logic signed [15:0] qz, logic signed [15:0] qw);
      qte_tb_pkg::euler_type e;
      longint x, y, z, w, sr, cr, sp, sy, cy, p, sq;
      x = qx; y = qy; z = qz; w = qw;
      sr = 2 * (w * x + y * z);
      cr = ONE28 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = ONE28 - 2 * (y * y + z * z);
      e.roll = 16'(round_angle(vector_angle(sr, cr), 25736));
      e.yaw = 16'(round_angle(vector_angle(sy, cy), 25736));
      if (sp >= ONE28 || sp <= -ONE28) begin
         p = (sp > 0) ? 12868 : -12868;
         e.clamped = 1'b1;
      end else begin
         sq = (sp < 0) ? -sp : sp;
         p = round_angle(vector_angle(sp, floor_sqrt((64'd1 << 56) - sq * sq)), 12868);
         e.clamped = 1'b0;
      end
      e.pitch = 15'(p);
      return e;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("Mismatch on %s at beat %0d: got %0d, expected %0d.",
               what, beats_checked, got, want);
   endtask

   // Result checker with its own stall pattern.
   always @(posedge clock) begin
      qte_tb_pkg::euler_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (angle_queue.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = angle_queue.pop_front();
               if (rsp_bus.roll_angle !== want.roll)
                  report_mismatch("roll", rsp_bus.roll_angle, want.roll);
               if (rsp_bus.pitch_angle !== want.pitch)
                  report_mismatch("pitch", rsp_bus.pitch_angle, want.pitch);
               if (rsp_bus.yaw_angle !== want.yaw)
                  report_mismatch("yaw", rsp_bus.yaw_angle, want.yaw);
               if (rsp_bus.pitch_clamped !== want.clamped)
                  report_mismatch("clamp", rsp_bus.pitch_clamped, want.clamped);
               if (want.clamped) clamps_seen++;
            end
            beats_checked++;
         end
         rsp_bus.ready <= ((cycles / 300) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
      int gap;
      qte_tb_pkg::euler_type expected;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.quat_x <= qx;
      req_bus.quat_y <= qy;
      req_bus.quat_z <= qz;
      req_bus.quat_w <= qw;
      expected = predict_angles(qx, qy, qz, qw);
      angle_queue = {angle_queue, expected};
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   function automatic logic signed [15:0] rand_comp();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   task automatic test_extremes();
      int v[5] = '{-16384, 16384, 0, 11585, -11585};
      for (int i = 0; i < 5; i++)
         send_quat(16'(v[i]), 16'(v[(i + 1) % 5]), 16'(v[(i + 2) % 5]), 16'(v[(i + 3) % 5]));
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
      send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
      send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
      send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
      send_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
      send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (angle_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_unit_quaternions();
      real a, b, c, d, n;
      for (int i = 0; i < 1000; i++) begin
         a = $itor($signed($urandom_range(0, 2000)) - 1000);
         b = $itor($signed($urandom_range(0, 2000)) - 1000);
         c = $itor($signed($urandom_range(0, 2000)) - 1000);
         d = $itor($signed($urandom_range(0, 2000)) - 1000);
         n = $sqrt(a * a + b * b + c * c + d * d) + 0.001;
         send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                   16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
      end
   endtask

   task automatic test_gimbal_lock();
      int s;
      for (int i = 0; i < 200; i++) begin
         s = $urandom_range(11570, 11600);
         send_quat(16'($urandom_range(0, 40)), 16'(($urandom_range(0, 1)) ? s : -s),
                   16'($urandom_range(0, 40)), 16'(s));
      end
   endtask

   task automatic test_raw_patterns();
      for (int i = 0; i < 300; i++)
         send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < 180; i++)
         send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.quat_x = '0;
      req_bus.quat_y = '0;
      req_bus.quat_z = '0;
      req_bus.quat_w = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      drain_results();
      test_unit_quaternions();
      test_gimbal_lock();
      drain_results();
      test_raw_patterns();
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d quaternion beats and checked %0d results, %0d with pitch clamped.",
               beats_sent, beats_checked, clamps_seen);
      $display("Covered axis extremes, unit quaternions, gimbal lock and raw bit patterns.");
      if (errors == 0 && angle_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
